// ===== rtl/core/ptshift_pkg.sv =====
package ptshift_pkg;

    localparam int unsigned COEF_W  = 32;
    localparam int unsigned DEG_W   = 4;
    localparam int unsigned CFG_A_W = 1;

    localparam logic [CFG_A_W-1:0] CFG_SHIFT_POINT = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_DEGREE      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP_RD,
        ST_TOP_LD,
        ST_MUL,
        ST_ADD,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic store;
        logic ld_top;
        logic mul;
        logic add;
        logic restart;
        logic ld_out;
        logic last;
    } t_cmd;

endpackage

// ===== rtl/core/polynomial_taylor_shift.sv =====
// channel   | direction | tdata (low bit up)                          | tuser | tlast
// s_axis    | in        | coefficient[31:0]                           | -     | -
// m_axis    | out       | shifted_coefficient[31:0], power_index[35:32] | -   | last
// cfg       | in        | i_cfg_addr 0: shift_point, 1: degree          | -   | -
//
// loading takes one item per cycle while idle; the item that completes n+1 coefficients starts a run
// a run of degree n above zero loads the top coefficient, then steps through the coefficient ram
// with a multiply and an add per step on one shared 32x32 multiplier, then reads, loads and holds
// each of its n+1 results in turn; degree zero goes straight to its single result
// no item is taken while a run is busy; m_axis stalls simply extend the run
// synchronous active-low reset clears the load count, degree and shift point
module polynomial_taylor_shift #(
    parameter int unsigned MAX_COEFFICIENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // coefficient
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // shifted_coefficient, power_index, zero pad
    output logic        m_axis_tlast
);

    localparam int unsigned IDX_W = $clog2(MAX_COEFFICIENTS);

    ptshift_pkg::t_cmd  w_cmd;
    logic [IDX_W-1:0]   w_waddr;
    logic [IDX_W-1:0]   w_raddr;
    logic [31:0]        w_shifted;
    logic [3:0]         w_power;

    ptshift_ctrl #(
        .MAX_COEFFICIENTS (MAX_COEFFICIENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .o_waddr     (w_waddr),
        .o_raddr     (w_raddr)
    );

    ptshift_dp #(
        .MAX_COEFFICIENTS (MAX_COEFFICIENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_waddr    (w_waddr),
        .i_raddr    (w_raddr),
        .i_coef     (s_axis_tdata),
        .o_shifted  (w_shifted),
        .o_power    (w_power),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_power, w_shifted};

endmodule

// ===== rtl/core/ptshift_ram.sv =====
module ptshift_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ptshift_dp.sv =====
module ptshift_dp #(
    parameter int unsigned MAX_COEFFICIENTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptshift_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  logic [ptshift_pkg::COEF_W-1:0]      i_cfg_data,
    input  ptshift_pkg::t_cmd                   i_cmd,
    input  logic [$clog2(MAX_COEFFICIENTS)-1:0] i_waddr,
    input  logic [$clog2(MAX_COEFFICIENTS)-1:0] i_raddr,
    input  logic [ptshift_pkg::COEF_W-1:0]      i_coef,
    output logic [ptshift_pkg::COEF_W-1:0]      o_shifted,
    output logic [ptshift_pkg::DEG_W-1:0]       o_power,
    output logic                                o_last
);

    logic signed [31:0] r_shift_point;
    logic signed [31:0] r_top;
    logic signed [31:0] r_prev;
    logic signed [63:0] r_prod;
    logic        [31:0] r_out;
    logic        [3:0]  r_power;
    logic               r_last;

    logic               w_we;
    logic        [31:0] w_wdata;
    logic        [31:0] w_rdata;
    logic signed [48:0] w_sum_wide;
    logic signed [31:0] w_sum;

    ptshift_ram #(
        .WIDTH (ptshift_pkg::COEF_W),
        .DEPTH (MAX_COEFFICIENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    // the q32.32 product floored to 16 fraction bits is its top 48 bits
    assign w_sum_wide = {{17{w_rdata[31]}}, w_rdata} + {r_prod[63], r_prod[63:16]};

    always_comb begin
        if (w_sum_wide[48:31] == {18{1'b0}} || w_sum_wide[48:31] == {18{1'b1}}) begin
            w_sum = w_sum_wide[31:0];
        end else if (w_sum_wide[48]) begin
            w_sum = 32'sh8000_0000;
        end else begin
            w_sum = 32'sh7fff_ffff;
        end
    end

    assign w_we    = i_cmd.store | i_cmd.add;
    assign w_wdata = i_cmd.store ? i_coef : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_point <= '0;
        end else if (i_cfg_we && i_cfg_addr == ptshift_pkg::CFG_SHIFT_POINT) begin
            r_shift_point <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_top) begin
            r_top  <= w_rdata;
            r_prev <= w_rdata;
        end else if (i_cmd.add) begin
            r_prev <= i_cmd.restart ? r_top : w_sum;
        end
        if (i_cmd.mul) begin
            r_prod <= r_shift_point * r_prev;
        end
        if (i_cmd.ld_out) begin
            r_out   <= w_rdata;
            r_power <= 4'(i_raddr);
            r_last  <= i_cmd.last;
        end
    end

    assign o_shifted = r_out;
    assign o_power   = r_power;
    assign o_last    = r_last;

endmodule

// ===== rtl/core/ptshift_ctrl.sv =====
module ptshift_ctrl #(
    parameter int unsigned MAX_COEFFICIENTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptshift_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  logic [ptshift_pkg::COEF_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ptshift_pkg::t_cmd                   o_cmd,
    output logic [$clog2(MAX_COEFFICIENTS)-1:0] o_waddr,
    output logic [$clog2(MAX_COEFFICIENTS)-1:0] o_raddr
);

    localparam int unsigned IDX_W = $clog2(MAX_COEFFICIENTS);

    ptshift_pkg::t_state r_state, n_state;
    logic [3:0]       r_degree;
    logic [IDX_W-1:0] r_n,   n_n;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_i,   n_i;
    logic [IDX_W-1:0] r_k,   n_k;
    logic [IDX_W-1:0] r_j,   n_j;
    logic [IDX_W-1:0] w_n_cur;

    // degree clamped to the store size
    assign w_n_cur = (32'(r_degree) > 32'(MAX_COEFFICIENTS - 1))
                   ? IDX_W'(MAX_COEFFICIENTS - 1) : IDX_W'(r_degree);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptshift_pkg::ST_IDLE;
            r_degree <= '0;
            r_n      <= '0;
            r_cnt    <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_j      <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_k     <= n_k;
            r_j     <= n_j;
            if (i_cfg_we && i_cfg_addr == ptshift_pkg::CFG_DEGREE) begin
                r_degree <= i_cfg_data[3:0];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_k         = r_k;
        n_j         = r_j;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_waddr     = r_cnt;
        o_raddr     = r_j;
        case (r_state)
            ptshift_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (r_cnt >= w_n_cur) begin
                        n_cnt   = '0;
                        n_n     = w_n_cur;
                        n_j     = '0;
                        n_state = (w_n_cur == '0) ? ptshift_pkg::ST_OUT_RD
                                                  : ptshift_pkg::ST_TOP_RD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ptshift_pkg::ST_TOP_RD: begin
                o_raddr = r_n;
                n_state = ptshift_pkg::ST_TOP_LD;
            end
            ptshift_pkg::ST_TOP_LD: begin
                o_cmd.ld_top = 1'b1;
                n_i          = '0;
                n_k          = r_n - 1'b1;
                n_state      = ptshift_pkg::ST_MUL;
            end
            ptshift_pkg::ST_MUL: begin
                o_raddr   = r_k;
                o_cmd.mul = 1'b1;
                n_state   = ptshift_pkg::ST_ADD;
            end
            ptshift_pkg::ST_ADD: begin
                o_raddr       = r_k;
                o_waddr       = r_k;
                o_cmd.add     = 1'b1;
                o_cmd.restart = (r_k == r_i);
                if (r_k == r_i) begin
                    if (r_i == r_n - 1'b1) begin
                        n_state = ptshift_pkg::ST_OUT_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_k     = r_n - 1'b1;
                        n_state = ptshift_pkg::ST_MUL;
                    end
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = ptshift_pkg::ST_MUL;
                end
            end
            ptshift_pkg::ST_OUT_RD: begin
                n_state = ptshift_pkg::ST_OUT_LD;
            end
            ptshift_pkg::ST_OUT_LD: begin
                o_cmd.ld_out = 1'b1;
                o_cmd.last   = (r_j == r_n);
                n_state      = ptshift_pkg::ST_OUT_WAIT;
            end
            ptshift_pkg::ST_OUT_WAIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_j == r_n) begin
                        n_state = ptshift_pkg::ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ptshift_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ptshift_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ptshift_check.sv =====
module ptshift_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // after the final result the block is back to loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("not ready after last result");

    // a middle result is followed by a gap while the next is read
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid && !s_axis_tready)
        else $error("unexpected state after middle result");

    // highest power is always the last of a run
    a_top_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[35:32] == 4'd15 |-> m_axis_tlast)
        else $error("power 15 without last");

endmodule

bind polynomial_taylor_shift ptshift_check u_ptshift_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
